@@ rtl/core/irm_pkg.sv @@
// Shared types and constants for the I2C register access master.
// Depends on nothing; imported by every module of the block.
package irm_pkg;

   // Operation codes carried by a request
   typedef enum logic [1:0] {
      OP_READ_BYTE  = 2'd0,
      OP_READ_WORD  = 2'd1,
      OP_WRITE_BYTE = 2'd2,
      OP_PROBE      = 2'd3
   } op_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT = 1'd1;
   localparam int unsigned CSR_DATA_W = 12;

   localparam logic [11:0] HALF_PERIOD_RESET = 12'd100;
   localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

   // Request queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   // One clock tick of the bus, as classified by the front part
   typedef struct packed {
      logic       start_req;
      op_type     operation;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_item_type;

   // Head of the request queue as seen by the engine
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } queue_head_type;

endpackage

@@ rtl/core/irm_front.sv @@
// Front part of the I2C register access master: accepts and classifies requests
// and holds them in a short queue. Depends on irm_pkg.
module irm_front
   import irm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           req_start_req,
   input  logic [1:0]     req_operation,
   input  logic [6:0]     req_device_address,
   input  logic [7:0]     req_register_address,
   input  logic [7:0]     req_write_data,
   input  logic           req_sda_in,
   output queue_head_type head,
   input  logic           pop
);

   req_item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic                         push;
   logic                         do_pop;
   req_item_type                 new_item;

   // classify the operation field
   always_comb begin
      new_item.start_req        = req_start_req;
      unique case (req_operation)
         OP_READ_BYTE:  new_item.operation = OP_READ_BYTE;
         OP_READ_WORD:  new_item.operation = OP_READ_WORD;
         OP_WRITE_BYTE: new_item.operation = OP_WRITE_BYTE;
         default:       new_item.operation = OP_PROBE;
      endcase
      new_item.device_address   = req_device_address;
      new_item.register_address = req_register_address;
      new_item.write_data       = req_write_data;
      new_item.sda_in           = req_sda_in;
   end

   assign req_stall  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/core/irm_engine.sv @@
// Back part of the I2C register access master: bus sequencer stepped once per
// queued request, with the response register. Depends on irm_pkg.
module irm_engine
   import irm_pkg::*;
#(
   parameter int unsigned DIVIDER_WIDTH = 12
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   input  logic [11:0]    half_period_ticks,
   input  logic [7:0]     ack_timeout,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_scl_out,
   output logic           rsp_sda_pull_low,
   output logic           rsp_busy_res,
   output logic           rsp_done_res,
   output logic [15:0]    rsp_read_data,
   output logic           rsp_ack_error,
   output logic           rsp_device_present
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_START, PH_SEND_AW, PH_ACK_AW, PH_SEND_REG, PH_ACK_REG,
      PH_SEND_DATA, PH_ACK_DATA, PH_RESTART, PH_SEND_AR, PH_ACK_AR,
      PH_RECV_LO, PH_MACK_LO, PH_RECV_HI, PH_MACK_HI, PH_STOP
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [3:0]               bit_ff, bit_in;
   logic [DIVIDER_WIDTH-1:0] tick_ff, tick_in;
   logic [7:0]               shift_ff, shift_in;
   logic [15:0]              data_ff, data_in;
   logic [7:0]               wait_ff, wait_in;
   op_type                   op_ff, op_in;
   logic [6:0]               dev_ff, dev_in;
   logic [7:0]               reg_ff, reg_in;
   logic [7:0]               wbyte_ff, wbyte_in;
   logic                     err_ff, err_in;

   logic                     rsp_valid_ff;
   logic                     scl, pull, busy, done;
   logic [15:0]              half_ext;
   logic [DIVIDER_WIDTH-1:0] half, half_m1, tick_inc;
   logic                     seg_end;
   req_item_type             it;

   assign it       = head.item;
   assign half_ext = {4'd0, half_period_ticks};
   assign half     = half_ext[DIVIDER_WIDTH-1:0];
   assign half_m1  = (half == '0) ? '0 : half - 1'b1;
   assign seg_end  = (tick_ff >= half_m1);
   assign tick_inc = tick_ff + 1'b1;

   // step on a queued request when the response register is free or drains
   assign pop       = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      data_in  = data_ff;
      wait_in  = wait_ff;
      op_in    = op_ff;
      dev_in   = dev_ff;
      reg_in   = reg_ff;
      wbyte_in = wbyte_ff;
      err_in   = err_ff;
      scl      = 1'b1;
      pull     = 1'b0;
      busy     = 1'b1;
      done     = 1'b0;

      unique case (phase_ff)
         PH_START, PH_RESTART: begin
            scl  = (bit_ff != 4'd0);
            pull = (bit_ff >= 4'd2);
            if (!seg_end) begin
               tick_in = tick_inc;
            end else if (bit_ff < 4'd2) begin
               tick_in = '0;
               bit_in  = bit_ff + 1'b1;
            end else begin
               bit_in  = '0;
               tick_in = '0;
               wait_in = '0;
               if (phase_ff == PH_START) begin
                  phase_in = PH_SEND_AW;
                  shift_in = {dev_ff, 1'b0};
               end else begin
                  phase_in = PH_SEND_AR;
                  shift_in = {dev_ff, 1'b1};
               end
            end
         end
         PH_SEND_AW, PH_SEND_REG, PH_SEND_DATA, PH_SEND_AR: begin
            scl  = bit_ff[0];
            pull = !shift_ff[7];
            if (!seg_end) begin
               tick_in = tick_inc;
            end else begin
               tick_in = '0;
               if (bit_ff[0]) begin
                  shift_in = {shift_ff[6:0], 1'b0};
               end
               if (bit_ff == 4'd15) begin
                  bit_in  = '0;
                  wait_in = '0;
                  case (phase_ff)
                     PH_SEND_AW:   phase_in = PH_ACK_AW;
                     PH_SEND_REG:  phase_in = PH_ACK_REG;
                     PH_SEND_DATA: phase_in = PH_ACK_DATA;
                     default:      phase_in = PH_ACK_AR;
                  endcase
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
            end
         end
         PH_ACK_AW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_AR: begin
            scl = (bit_ff != 4'd0);
            if (!seg_end) begin
               tick_in = tick_inc;
            end else if (bit_ff == 4'd0) begin
               tick_in = '0;
               bit_in  = 4'd1;
            end else if (!it.sda_in) begin
               // slave acknowledged: choose the next byte
               bit_in  = '0;
               tick_in = '0;
               wait_in = '0;
               case (phase_ff)
                  PH_ACK_AW: begin
                     if (op_ff == OP_PROBE) begin
                        phase_in = PH_STOP;
                     end else begin
                        phase_in = PH_SEND_REG;
                        shift_in = reg_ff;
                     end
                  end
                  PH_ACK_REG: begin
                     if (op_ff == OP_WRITE_BYTE) begin
                        phase_in = PH_SEND_DATA;
                        shift_in = wbyte_ff;
                     end else begin
                        phase_in = PH_RESTART;
                     end
                  end
                  PH_ACK_AR: begin
                     phase_in = PH_RECV_LO;
                     shift_in = '0;
                  end
                  default: phase_in = PH_STOP;
               endcase
            end else if (wait_ff >= ack_timeout) begin
               // give up and release the bus
               err_in   = 1'b1;
               phase_in = PH_STOP;
               bit_in   = '0;
               tick_in  = '0;
               wait_in  = '0;
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
         PH_RECV_LO, PH_RECV_HI: begin
            scl = bit_ff[0];
            if (!seg_end) begin
               tick_in = tick_inc;
            end else begin
               tick_in = '0;
               if (bit_ff[0]) begin
                  shift_in = {shift_ff[6:0], it.sda_in};
               end
               if (bit_ff == 4'd15) begin
                  if (phase_ff == PH_RECV_LO) begin
                     data_in  = {8'd0, shift_in};
                     phase_in = PH_MACK_LO;
                  end else begin
                     data_in  = {shift_in, data_ff[7:0]};
                     phase_in = PH_MACK_HI;
                  end
                  bit_in  = '0;
                  wait_in = '0;
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
            end
         end
         PH_MACK_LO, PH_MACK_HI: begin
            scl  = (bit_ff != 4'd0);
            pull = (phase_ff == PH_MACK_LO) && (op_ff == OP_READ_WORD);
            if (!seg_end) begin
               tick_in = tick_inc;
            end else if (bit_ff == 4'd0) begin
               tick_in = '0;
               bit_in  = 4'd1;
            end else begin
               bit_in  = '0;
               tick_in = '0;
               wait_in = '0;
               if (pull) begin
                  phase_in = PH_RECV_HI;
                  shift_in = '0;
               end else begin
                  phase_in = PH_STOP;
               end
            end
         end
         PH_STOP: begin
            scl  = (bit_ff != 4'd0);
            pull = (bit_ff < 4'd2);
            if (!seg_end) begin
               tick_in = tick_inc;
            end else if (bit_ff < 4'd2) begin
               tick_in = '0;
               bit_in  = bit_ff + 1'b1;
            end else begin
               phase_in = PH_IDLE;
               bit_in   = '0;
               tick_in  = '0;
               wait_in  = '0;
               done     = 1'b1;
            end
         end
         default: begin
            busy     = 1'b0;
            phase_in = PH_IDLE;
            bit_in   = '0;
            tick_in  = '0;
            wait_in  = '0;
            if (it.start_req) begin
               op_in    = it.operation;
               dev_in   = it.device_address;
               reg_in   = it.register_address;
               wbyte_in = it.write_data;
               data_in  = '0;
               err_in   = 1'b0;
               shift_in = '0;
               phase_in = PH_START;
               bit_in   = 4'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_ff       <= '0;
         tick_ff      <= '0;
         shift_ff     <= '0;
         data_ff      <= '0;
         wait_ff      <= '0;
         op_ff        <= OP_READ_BYTE;
         dev_ff       <= '0;
         reg_ff       <= '0;
         wbyte_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         phase_ff           <= phase_in;
         bit_ff             <= bit_in;
         tick_ff            <= tick_in;
         shift_ff           <= shift_in;
         data_ff            <= data_in;
         wait_ff            <= wait_in;
         op_ff              <= op_in;
         dev_ff             <= dev_in;
         reg_ff             <= reg_in;
         wbyte_ff           <= wbyte_in;
         err_ff             <= err_in;
         rsp_valid_ff       <= 1'b1;
         rsp_scl_out        <= scl;
         rsp_sda_pull_low   <= pull;
         rsp_busy_res       <= busy;
         rsp_done_res       <= done;
         rsp_read_data      <= data_in;
         rsp_ack_error      <= err_in;
         rsp_device_present <= (phase_in == PH_IDLE) && (op_in == OP_PROBE) && !err_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

@@ rtl/core/i2c_register_access_master_core.sv @@
// Top level of the I2C register access master: configuration registers,
// request queue front and bus sequencer back. Depends on irm_pkg, irm_front,
// irm_engine.
//
// Usage: every request is one clock tick of the bus. It carries a start strobe,
// the operation, device and register addresses, write data and the sampled SDA
// level. Every accepted request yields exactly one response with the SCL and
// SDA drive levels, busy and done flags, the data read, the acknowledge error
// and the probe result. Operations are read byte, read two bytes, write byte
// and probe; a missing acknowledge ends the transfer with a STOP.
// Path: an accepted request is written into the request queue, and its response
// is registered in the response register when the sequencer steps on it.
// Throughput: one request and one sequencer step per cycle unless stalled.
// A four-entry request queue parts the front from the sequencer, and the
// response register parts the sequencer from the receiver, so a stalled
// receiver holds the response and the queue keeps taking requests until full.
// Reset: synchronous; empties the queue, drops the response, returns the
// sequencer to idle and loads half period 100 and acknowledge timeout 250.
// Write the configuration only while no request is in flight.
module i2c_register_access_master_core
   import irm_pkg::*;
#(
   parameter int unsigned DIVIDER_WIDTH = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_start_req,
   input  logic [1:0]             req_operation,
   input  logic [6:0]             req_device_address,
   input  logic [7:0]             req_register_address,
   input  logic [7:0]             req_write_data,
   input  logic                   req_sda_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_scl_out,
   output logic                   rsp_sda_pull_low,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic [15:0]            rsp_read_data,
   output logic                   rsp_ack_error,
   output logic                   rsp_device_present,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [11:0]    half_period_ff;
   logic [7:0]     ack_timeout_ff;
   queue_head_type head;
   logic           pop;

   // configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_write_data;
            CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   irm_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_start_req        (req_start_req),
      .req_operation        (req_operation),
      .req_device_address   (req_device_address),
      .req_register_address (req_register_address),
      .req_write_data       (req_write_data),
      .req_sda_in           (req_sda_in),
      .head                 (head),
      .pop                  (pop)
   );

   irm_engine #(
      .DIVIDER_WIDTH (DIVIDER_WIDTH)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .half_period_ticks  (half_period_ff),
      .ack_timeout        (ack_timeout_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_scl_out        (rsp_scl_out),
      .rsp_sda_pull_low   (rsp_sda_pull_low),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_read_data      (rsp_read_data),
      .rsp_ack_error      (rsp_ack_error),
      .rsp_device_present (rsp_device_present)
   );

endmodule
